>>> sv/bthc_pkg.sv
// ----------------------------------------------------------------------------
// bthc_pkg
// Shared types and constants of the button tap/hold classifier: request
// payloads, phase and gesture codes, register map.
// ----------------------------------------------------------------------------
package bthc_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  localparam logic [PaddrW-1:0] AddrDebounce = 4'h0;
  localparam logic [PaddrW-1:0] AddrTapLimit = 4'h4;
  localparam logic [PaddrW-1:0] AddrHoldTime = 4'h8;

  localparam logic [CfgW-1:0] DebounceRst = 16'd30;
  localparam logic [CfgW-1:0] TapLimitRst = 16'd400;
  localparam logic [CfgW-1:0] HoldTimeRst = 16'd2000;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_PRESSED = 2'd1,
    PHASE_HOLD    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    GEST_NONE = 2'd0,
    GEST_TAP  = 2'd1,
    GEST_HOLD = 2'd2
  } gesture_t;

  typedef struct packed {
    logic             command;
    logic             pressed;
    logic [TimeW-1:0] now_time;
  } in_req_t;

  typedef struct packed {
    logic [1:0]       gesture;
    logic [1:0]       phase;
    logic             stable_level;
    logic [TimeW-1:0] held_time;
  } out_req_t;

endpackage

>>> sv/button_tap_hold_classifier_unit.sv
// An accepted request goes through the input register and the result register
// to out_data. Throughput: one request per cycle while out_stall holds no result;
// the classification state is updated as each request enters the result register.
// Reset: synchronous, active low; clears the debounce and phase state,
// both valid flags, and loads the timing registers with 30, 400 and 2000 ms.
// ----------------------------------------------------------------------------
// button_tap_hold_classifier_unit
// Debounces button samples and, on release, classifies a debounced press as a tap,
// a hold or neither (between the two limits), with arming to swallow the next press.
// ----------------------------------------------------------------------------
module button_tap_hold_classifier_unit
  import bthc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [CfgW-1:0] debounce_time_r, tap_limit_r, hold_time_r;

  logic             s1_valid_r;
  in_req_t          s1_data_r;
  logic             out_valid_r;
  out_req_t         out_data_r;

  logic             raw_level_r, raw_level_nxt;
  logic [TimeW-1:0] raw_change_time_r, raw_change_time_nxt;
  logic             debounced_level_r, debounced_level_nxt;
  logic [TimeW-1:0] press_start_time_r, press_start_time_nxt;
  logic             swallow_armed_r, swallow_armed_nxt;
  phase_t           button_phase_r, button_phase_nxt;

  logic             adv, fire, cfg_wr;
  logic             settle, press_edge, edge_up;
  logic [TimeW-1:0] since_change, held;
  gesture_t         gesture;
  out_req_t         result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= DebounceRst;
      tap_limit_r     <= TapLimitRst;
      hold_time_r     <= HoldTimeRst;
    end else if (cfg_wr) begin
      unique case (paddr)
        AddrDebounce: debounce_time_r <= pwdata[CfgW-1:0];
        AddrTapLimit: tap_limit_r     <= pwdata[CfgW-1:0];
        AddrHoldTime: hold_time_r     <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrDebounce: prdata = {{(PdataW-CfgW){1'b0}}, debounce_time_r};
      AddrTapLimit: prdata = {{(PdataW-CfgW){1'b0}}, tap_limit_r};
      AddrHoldTime: prdata = {{(PdataW-CfgW){1'b0}}, hold_time_r};
      default:      prdata = '0;
    endcase
  end

  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  always_comb begin
    raw_level_nxt        = raw_level_r;
    raw_change_time_nxt  = raw_change_time_r;
    debounced_level_nxt  = debounced_level_r;
    press_start_time_nxt = press_start_time_r;
    swallow_armed_nxt    = swallow_armed_r;
    button_phase_nxt     = button_phase_r;
    gesture              = GEST_NONE;
    settle               = 1'b0;
    press_edge           = 1'b0;
    edge_up              = 1'b0;
    since_change         = '0;
    held                 = '0;
    if (s1_data_r.command) begin
      swallow_armed_nxt = 1'b1;
    end else begin
      if (s1_data_r.pressed != raw_level_r) begin
        raw_level_nxt       = s1_data_r.pressed;
        raw_change_time_nxt = s1_data_r.now_time;
      end
      since_change = s1_data_r.now_time - raw_change_time_nxt;
      settle = (since_change >= {{(TimeW-CfgW){1'b0}}, debounce_time_r}) &&
               (debounced_level_r != raw_level_nxt);
      if (settle) begin
        debounced_level_nxt = raw_level_nxt;
        if (raw_level_nxt) begin
          press_start_time_nxt = s1_data_r.now_time;
        end
      end
      press_edge = !debounced_level_r && debounced_level_nxt;
      edge_up    = debounced_level_r && !debounced_level_nxt;
      held       = s1_data_r.now_time - press_start_time_nxt;
      if (press_edge && swallow_armed_r) begin
        button_phase_nxt = PHASE_IDLE;
      end else if (swallow_armed_r) begin
        if (edge_up) begin
          swallow_armed_nxt = 1'b0;
        end
      end else if (edge_up) begin
        button_phase_nxt = PHASE_IDLE;
        if (held >= {{(TimeW-CfgW){1'b0}}, hold_time_r}) begin
          gesture = GEST_HOLD;
        end else if (held < {{(TimeW-CfgW){1'b0}}, tap_limit_r}) begin
          gesture = GEST_TAP;
        end
      end else begin
        if (press_edge) begin
          button_phase_nxt = PHASE_PRESSED;
        end
        if (debounced_level_nxt && held >= {{(TimeW-CfgW){1'b0}}, hold_time_r}) begin
          button_phase_nxt = PHASE_HOLD;
        end
      end
    end
    result.gesture      = gesture;
    result.phase        = button_phase_nxt;
    result.stable_level = debounced_level_nxt;
    result.held_time    = debounced_level_nxt ?
                          (s1_data_r.now_time - press_start_time_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_level_r        <= 1'b0;
      raw_change_time_r  <= '0;
      debounced_level_r  <= 1'b0;
      press_start_time_r <= '0;
      swallow_armed_r    <= 1'b0;
      button_phase_r     <= PHASE_IDLE;
    end else if (fire) begin
      raw_level_r        <= raw_level_nxt;
      raw_change_time_r  <= raw_change_time_nxt;
      debounced_level_r  <= debounced_level_nxt;
      press_start_time_r <= press_start_time_nxt;
      swallow_armed_r    <= swallow_armed_nxt;
      button_phase_r     <= button_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_held_zero_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.stable_level |-> out_data_r.held_time == '0)
    else $error("held_time nonzero while released");

  a_gesture_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.gesture != GEST_NONE |->
      out_data_r.phase == PHASE_IDLE && !out_data_r.stable_level)
    else $error("gesture reported outside a release");

  a_disarm_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(swallow_armed_r) |->
      $past(debounced_level_r) && !debounced_level_r)
    else $error("swallow cleared without a release");

  a_press_start_time: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(debounced_level_r) |->
      press_start_time_r == $past(s1_data_r.now_time))
    else $error("press start time not taken from the press request");

endmodule

>>> verif/bthc_gesture_checker.sv
// ----------------------------------------------------------------------------
// bthc_gesture_checker
// Watches the request, result and register ports of the button tap/hold
// classifier, predicts the result of every accepted request from its own copy
// of the debounce and phase state, and compares each result field by field.
// ----------------------------------------------------------------------------
module bthc_gesture_checker
  import bthc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_req_t           in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_req_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output int                mismatch_count,
  output int                gestures_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CfgW-1:0]  debounce_ms;
  logic [CfgW-1:0]  tap_ms;
  logic [CfgW-1:0]  hold_ms;

  logic             raw_lvl;
  logic [TimeW-1:0] raw_change_ms;
  logic             deb_lvl;
  logic [TimeW-1:0] press_start_ms;
  logic             armed;
  phase_t           phase_q;

  out_req_t         pending_gestures[$];

  function automatic out_req_t predict_gesture(in_req_t req);
    out_req_t         res;
    gesture_t         gest;
    logic             was_down;
    logic             press_edge;
    logic             edge_up;
    logic [TimeW-1:0] span;
    gest = GEST_NONE;
    if (req.command) begin
      armed = 1'b1;
    end else begin
      if (req.pressed != raw_lvl) begin
        raw_lvl = req.pressed;
        raw_change_ms = req.now_time;
      end
      was_down = deb_lvl;
      span = req.now_time - raw_change_ms;
      if (span >= debounce_ms && deb_lvl != raw_lvl) begin
        deb_lvl = raw_lvl;
        if (deb_lvl) press_start_ms = req.now_time;
      end
      press_edge = !was_down && deb_lvl;
      edge_up = was_down && !deb_lvl;
      span = req.now_time - press_start_ms;
      if (press_edge && armed) begin
        phase_q = PHASE_IDLE;
      end else if (armed) begin
        if (edge_up) armed = 1'b0;
      end else begin
        if (press_edge) phase_q = PHASE_PRESSED;
        if (edge_up) begin
          phase_q = PHASE_IDLE;
          if (span >= hold_ms) gest = GEST_HOLD;
          else if (span < tap_ms) gest = GEST_TAP;
        end else if (deb_lvl && span >= hold_ms) begin
          phase_q = PHASE_HOLD;
        end
      end
    end
    res.gesture = gest;
    res.phase = phase_q;
    res.stable_level = deb_lvl;
    res.held_time = deb_lvl ? req.now_time - press_start_ms : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    out_req_t exp_res;
    logic     bad;
    if (!rst_n) begin
      debounce_ms = DebounceRst;
      tap_ms = TapLimitRst;
      hold_ms = HoldTimeRst;
      raw_lvl = 1'b0;
      raw_change_ms = '0;
      deb_lvl = 1'b0;
      press_start_ms = '0;
      armed = 1'b0;
      phase_q = PHASE_IDLE;
      pending_gestures.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          AddrDebounce: debounce_ms = pwdata[CfgW-1:0];
          AddrTapLimit: tap_ms = pwdata[CfgW-1:0];
          AddrHoldTime: hold_ms = pwdata[CfgW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_gestures.push_back(predict_gesture(in_data));
      if (out_valid && !out_stall) begin
        if (pending_gestures.size() == 0) begin
          $display("%0t: unexpected result, got gesture %0d phase %0d level %0d held %0d",
                   $time, out_data.gesture, out_data.phase, out_data.stable_level,
                   out_data.held_time);
          mismatch_count++;
        end else begin
          exp_res = pending_gestures.pop_front();
          bad = 1'b0;
          if (out_data.gesture !== exp_res.gesture) begin
            $display("%0t: gesture expected %0d, got %0d",
                     $time, exp_res.gesture, out_data.gesture);
            bad = 1'b1;
          end
          if (out_data.phase !== exp_res.phase) begin
            $display("%0t: phase expected %0d, got %0d",
                     $time, exp_res.phase, out_data.phase);
            bad = 1'b1;
          end
          if (out_data.stable_level !== exp_res.stable_level) begin
            $display("%0t: stable_level expected %0d, got %0d",
                     $time, exp_res.stable_level, out_data.stable_level);
            bad = 1'b1;
          end
          if (out_data.held_time !== exp_res.held_time) begin
            $display("%0t: held_time expected %0d, got %0d",
                     $time, exp_res.held_time, out_data.held_time);
            bad = 1'b1;
          end
          if (bad) mismatch_count++;
        end
      end
    end
    gestures_in_flight = pending_gestures.size();
  end

endmodule

>>> verif/tb_button_tap_hold_classifier_unit.sv
// ----------------------------------------------------------------------------
// tb_button_tap_hold_classifier_unit
// Drives button sample and arm requests into the tap/hold classifier under
// several timing settings (reset values, all zero, all maximum, random), with
// random idling on both channels and one long result hold-off, and reports
// the verdict from the checker's mismatch count and in-flight count.
// ----------------------------------------------------------------------------
module tb_button_tap_hold_classifier_unit;
  import bthc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int ItemsPerPhase = 270;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_stall;
  out_req_t          out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  int                mismatch_count;
  int                gestures_in_flight;
  int                cycle_count = 0;
  int                requests_sent = 0;
  bit                idle_gaps = 1'b1;
  bit                squeeze_req = 1'b0;
  bit                squeeze_done = 1'b0;
  logic [TimeW-1:0]  clock_ms = '0;
  logic [CfgW-1:0]   cur_debounce = DebounceRst;
  logic [CfgW-1:0]   cur_tap = TapLimitRst;
  logic [CfgW-1:0]   cur_hold = HoldTimeRst;

  button_tap_hold_classifier_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  bthc_gesture_checker i_gesture_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatch_count    (mismatch_count),
    .gestures_in_flight(gestures_in_flight)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic in_req_t make_request(logic cmd, logic lvl, logic [TimeW-1:0] t);
    in_req_t r;
    r.command = cmd;
    r.pressed = lvl;
    r.now_time = t;
    return r;
  endfunction

  task automatic send_request(in_req_t req);
    int gap;
    int pick;
    gap = 0;
    if (idle_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) gap = 0;
      else if (pick < 90) gap = $urandom_range(1, 3);
      else if (pick < 98) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic advance_and_sample(logic lvl, int unsigned step);
    clock_ms += step;
    send_request(make_request(1'b0, lvl, clock_ms));
  endtask

  task automatic arm_swallow();
    clock_ms += $urandom_range(0, 20);
    send_request(make_request(1'b1, 1'($urandom_range(0, 1)), clock_ms));
  endtask

  task automatic noise_request();
    logic [TimeW-1:0] t;
    t = $urandom_range(0, 1) ? $urandom() : clock_ms + $urandom_range(0, 3000);
    if ($urandom_range(0, 3) == 0) clock_ms = t;
    send_request(make_request($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)), t));
  endtask

  // bounce, then hold the level for span ms
  task automatic settle_level(logic lvl, int unsigned span);
    int unsigned hi;
    int unsigned elapsed;
    int unsigned step;
    hi = span / 6 + 1;
    if (span <= 300 && $urandom_range(0, 2) == 0) hi = 2;
    repeat ($urandom_range(0, 3)) begin
      advance_and_sample(lvl, $urandom_range(0, cur_debounce / 2 + 1));
      advance_and_sample(~lvl, $urandom_range(0, cur_debounce / 2 + 1));
    end
    advance_and_sample(lvl, $urandom_range(0, cur_debounce / 2 + 1));
    elapsed = 0;
    while (elapsed < span) begin
      step = $urandom_range(1, hi);
      elapsed += step;
      advance_and_sample(lvl, step);
    end
  endtask

  task automatic play_press();
    int unsigned tap;
    int unsigned hold;
    int unsigned press_len;
    tap = 32'(cur_tap);
    hold = 32'(cur_hold);
    case ($urandom_range(0, 4))
      0: press_len = $urandom_range(0, tap);
      1: press_len = $urandom_range(tap, hold);
      2: press_len = ((hold > 20) ? hold - 20 : 0) + $urandom_range(0, 40);
      3: press_len = ((tap > 20) ? tap - 20 : 0) + $urandom_range(0, 40);
      default: press_len = hold + $urandom_range(0, hold + 100);
    endcase
    if ($urandom_range(0, 5) == 0) arm_swallow();
    if ($urandom_range(0, 7) == 0) begin
      settle_level(1'b1, cur_debounce + press_len / 2);
      arm_swallow();
      settle_level(1'b1, press_len / 2);
    end else begin
      settle_level(1'b1, cur_debounce + press_len);
    end
    settle_level(1'b0, cur_debounce + $urandom_range(0, 60));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gestures_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [PaddrW-1:0] addr, logic [CfgW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {{(PdataW-CfgW){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_timing(logic [CfgW-1:0] deb, logic [CfgW-1:0] tap, logic [CfgW-1:0] hold);
    wait_drain();
    write_reg(AddrDebounce, deb);
    write_reg(AddrTapLimit, tap);
    write_reg(AddrHoldTime, hold);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_debounce = deb;
    cur_tap = tap;
    cur_hold = hold;
  endtask

  initial begin : receiver
    int burst;
    int pick;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        squeeze_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (pick < 30) out_stall <= 1'b0;
        else if (pick < 95) out_stall <= ($urandom_range(0, 99) < 35);
        else out_stall <= ($urandom_range(0, 99) < 90);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int goal;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tap, swallowed press, hold, middle length, wrap, arm during press
    idle_gaps = 1'b0;
    send_request(make_request(1'b0, 1'b0, 32'd0));
    send_request(make_request(1'b0, 1'b1, 32'd10));
    send_request(make_request(1'b0, 1'b1, 32'd40));
    send_request(make_request(1'b0, 1'b0, 32'd100));
    send_request(make_request(1'b0, 1'b0, 32'd130));
    send_request(make_request(1'b1, 1'b1, 32'd200));
    send_request(make_request(1'b0, 1'b1, 32'd210));
    send_request(make_request(1'b0, 1'b1, 32'd240));
    send_request(make_request(1'b0, 1'b0, 32'd3000));
    send_request(make_request(1'b0, 1'b0, 32'd3030));
    send_request(make_request(1'b0, 1'b1, 32'd4000));
    send_request(make_request(1'b0, 1'b1, 32'd4030));
    send_request(make_request(1'b0, 1'b1, 32'd6030));
    send_request(make_request(1'b0, 1'b0, 32'd6100));
    send_request(make_request(1'b0, 1'b0, 32'd6130));
    send_request(make_request(1'b0, 1'b1, 32'd7000));
    send_request(make_request(1'b0, 1'b1, 32'd7030));
    send_request(make_request(1'b0, 1'b0, 32'd8000));
    send_request(make_request(1'b0, 1'b0, 32'd8030));
    send_request(make_request(1'b0, 1'b1, 32'hFFFF_FFF0));
    send_request(make_request(1'b0, 1'b1, 32'h0000_0010));
    send_request(make_request(1'b1, 1'b0, 32'h0000_0020));
    send_request(make_request(1'b0, 1'b0, 32'h0000_0100));
    send_request(make_request(1'b0, 1'b0, 32'h0000_0200));
    set_timing(16'd0, 16'd0, 16'd0);
    send_request(make_request(1'b0, 1'b1, 32'd300));
    send_request(make_request(1'b0, 1'b0, 32'd300));
    clock_ms = 32'd400;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_timing(DebounceRst, TapLimitRst, HoldTimeRst);
        1: begin
          set_timing(CfgW'($urandom_range(0, 60)), CfgW'($urandom_range(0, 1500)),
                     CfgW'($urandom_range(200, 4000)));
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
        end
        2: set_timing(16'd0, 16'd0, 16'd0);
        3: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        4: set_timing(CfgW'($urandom_range(0, 20)), CfgW'($urandom_range(500, 3000)),
                      CfgW'($urandom_range(0, 400)));
        default: set_timing(CfgW'($urandom_range(0, 200)), CfgW'($urandom()),
                            CfgW'($urandom()));
      endcase
      if (ph == 1) begin
        idle_gaps = 1'b0;
        squeeze_req = 1'b1;
        while (!squeeze_done) begin
          if ($urandom_range(0, 5) == 0) noise_request();
          else advance_and_sample(1'($urandom_range(0, 1)), $urandom_range(0, 50));
        end
      end
      goal = 26 + (ph + 1) * ItemsPerPhase;
      while (requests_sent < goal) begin
        idle_gaps = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 6) == 0) noise_request();
        else play_press();
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && gestures_in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
